### sv/sida_pkg.sv
`default_nettype none

package sida_pkg;

    // Default width of the signed value taken in
    localparam int VALUE_WIDTH_DEF = 32;

    // ASCII codes, six bits wide as carried on the output
    localparam logic [5:0] CHAR_ZERO  = 6'd48;
    localparam logic [5:0] CHAR_MINUS = 6'd45;

    // BCD digit at or above this value is corrected by adding three before a shift
    localparam logic [3:0] BCD_ADJ_LIMIT = 4'd5;
    localparam logic [3:0] BCD_ADJ_ADD   = 4'd3;

    // Decimal digits needed for the largest magnitude 2^(w-1):
    // floor((w-1) * log10(2)) + 1, exact for 8 <= w <= 64
    function automatic int num_digits(input int w);
        num_digits = ((w - 1) * 30103) / 100000 + 1;
    endfunction

endpackage

`default_nettype wire

### sv/sida_bcd_step.sv
`default_nettype none

// One shift-and-add-3 step: correct each BCD digit, then shift in one binary bit.
module sida_bcd_step #(
    parameter int NDIG = 10
) (
    input  wire logic [NDIG*4-1:0] i_bcd,
    input  wire logic              i_bit,
    output logic      [NDIG*4-1:0] o_bcd
);

    logic [NDIG*4-1:0] w_adj;

    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            if (i_bcd[i*4 +: 4] >= sida_pkg::BCD_ADJ_LIMIT) begin
                w_adj[i*4 +: 4] = i_bcd[i*4 +: 4] + sida_pkg::BCD_ADJ_ADD;
            end else begin
                w_adj[i*4 +: 4] = i_bcd[i*4 +: 4];
            end
        end
    end

    assign o_bcd = {w_adj[NDIG*4-2:0], i_bit};

endmodule

`default_nettype wire

### sv/signed_int_to_decimal_ascii.sv
`default_nettype none

// Signed integer to decimal ASCII text.
// Input channel: one word per number (i_number, two's complement, VALUE_WIDTH
// bits), accepted when i_in_valid is high and o_in_stall is low.
// Output channel: one word per character (o_text_char, o_is_last), taken when
// o_out_valid is high and i_out_stall is low. A negative number starts with
// '-', digits follow most significant first with no leading zeros, zero gives
// a single '0'. o_is_last marks the final character of each number.
// Sequence: one shift-and-add-3 step per input bit in the single BCD step
// unit, a state to find the leading digit, then one character per cycle into
// the output register while the receiver does not stall.
// o_in_stall is high from acceptance until the last character has been loaded
// into the output register, so the next number is taken while that character
// still waits. When the receiver stalls, the output register holds its word
// and character emission pauses. Synchronous active-low reset empties the
// output register and returns the sequencer to idle.
module signed_int_to_decimal_ascii #(
    parameter int VALUE_WIDTH = sida_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic signed [VALUE_WIDTH-1:0] i_number,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic             [5:0]      o_text_char,
    output logic                        o_is_last
);

    localparam int NDIG  = sida_pkg::num_digits(VALUE_WIDTH);
    localparam int IDX_W = $clog2(NDIG);
    localparam int CNT_W = $clog2(VALUE_WIDTH);

    // sequencer codes
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CONV  = 2'd1;
    localparam logic [1:0] ST_COUNT = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]             r_state, n_state;
    logic [VALUE_WIDTH-1:0] r_magnitude, n_magnitude;
    logic [NDIG*4-1:0]      r_digit_store, n_digit_store;
    logic [CNT_W-1:0]       r_bit_cnt, n_bit_cnt;
    logic [IDX_W-1:0]       r_digit_idx, n_digit_idx;
    logic                   r_negative_flag, n_negative_flag;
    logic                   r_out_valid, n_out_valid;
    logic [5:0]             r_text_char, n_text_char;
    logic                   r_is_last, n_is_last;

    logic                   w_in_take;
    logic                   w_slot_free;
    logic [VALUE_WIDTH-1:0] w_abs;
    logic [NDIG*4-1:0]      w_step_bcd;
    logic [IDX_W-1:0]       w_top;
    logic [3:0]             w_digit;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_in_take   = i_in_valid && !o_in_stall;
    // output register can take a new word this cycle
    assign w_slot_free = !r_out_valid || !i_out_stall;

    // magnitude without sign: the most negative value wraps to 2^(W-1), which is exact
    assign w_abs = i_number[VALUE_WIDTH-1]
        ? (~$unsigned(i_number) + {{(VALUE_WIDTH-1){1'b0}}, 1'b1})
        : $unsigned(i_number);

    sida_bcd_step #(
        .NDIG (NDIG)
    ) u_bcd_step (
        .i_bcd (r_digit_store),
        .i_bit (r_magnitude[VALUE_WIDTH-1]),
        .o_bcd (w_step_bcd)
    );

    // leading non-zero digit; zero falls back to the units digit
    always_comb begin
        w_top = '0;
        for (int i = 1; i < NDIG; i++) begin
            if (r_digit_store[i*4 +: 4] != 4'd0) begin
                w_top = IDX_W'(i);
            end
        end
    end

    assign w_digit = r_digit_store[r_digit_idx*4 +: 4];

    always_comb begin
        n_state         = r_state;
        n_magnitude     = r_magnitude;
        n_digit_store   = r_digit_store;
        n_bit_cnt       = r_bit_cnt;
        n_digit_idx     = r_digit_idx;
        n_negative_flag = r_negative_flag;
        n_out_valid     = r_out_valid;
        n_text_char     = r_text_char;
        n_is_last       = r_is_last;

        // drop the word once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_take) begin
                    n_negative_flag = i_number[VALUE_WIDTH-1];
                    n_magnitude     = w_abs;
                    n_digit_store   = '0;
                    n_bit_cnt       = '0;
                    n_state         = ST_CONV;
                end
            end
            ST_CONV: begin
                n_digit_store = w_step_bcd;
                n_magnitude   = {r_magnitude[VALUE_WIDTH-2:0], 1'b0};
                n_bit_cnt     = r_bit_cnt + 1'b1;
                if (r_bit_cnt == CNT_W'(VALUE_WIDTH - 1)) begin
                    n_state = ST_COUNT;
                end
            end
            ST_COUNT: begin
                n_digit_idx = w_top;
                n_state     = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    if (r_negative_flag) begin
                        n_text_char     = sida_pkg::CHAR_MINUS;
                        n_is_last       = 1'b0;
                        n_negative_flag = 1'b0;
                    end else begin
                        n_text_char = sida_pkg::CHAR_ZERO + {2'b00, w_digit};
                        n_is_last   = (r_digit_idx == '0);
                        if (r_digit_idx == '0) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_digit_idx = r_digit_idx - 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_out_valid     <= 1'b0;
            r_negative_flag <= 1'b0;
            r_magnitude     <= '0;
        end else begin
            r_state         <= n_state;
            r_out_valid     <= n_out_valid;
            r_negative_flag <= n_negative_flag;
            r_magnitude     <= n_magnitude;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit_store <= n_digit_store;
        r_bit_cnt     <= n_bit_cnt;
        r_digit_idx   <= n_digit_idx;
        r_text_char   <= n_text_char;
        r_is_last     <= n_is_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_text_char = r_text_char;
    assign o_is_last   = r_is_last;

    // only a minus sign or a decimal digit leaves the block
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_text_char == sida_pkg::CHAR_MINUS
            || (o_text_char >= sida_pkg::CHAR_ZERO
                && o_text_char <= sida_pkg::CHAR_ZERO + 6'd9)))
        else $error("character out of range");

    // a sign is never the final character
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_text_char == sida_pkg::CHAR_MINUS) |-> !o_is_last)
        else $error("minus sign flagged as last");

    // leaving emission always leaves the last character in the output register
    a_end_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && n_state == ST_IDLE) |=> (o_out_valid && o_is_last))
        else $error("number ended without last flag");

    // an accepted word starts the conversion
    a_take_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_take |=> (r_state == ST_CONV && r_bit_cnt == '0))
        else $error("accepted word did not start conversion");

endmodule

`default_nettype wire
